FILE: src/sts_pkg.sv
// Shared types and constants for the sorted table search block.
`default_nettype none

package sts_pkg;

    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int LEN_W   = 11;
    localparam int POS_W   = 10;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_LOOK
    } t_state;

endpackage

`default_nettype wire

FILE: src/sts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: src/sorted_table_binary_search.sv
// Binary search over a sorted table held in one synchronous RAM.
// A write transfer leaves busy low. A search probes one entry per
// cycle; the result strobe is registered from the compare of the last probe,
// with the registered RAM read feeding each compare. An empty table answers
// without entering the search state. Synchronous active-low reset clears the
// length register and the sequencer; table contents are undefined until written
// and no clearing pass is run.
`default_nettype none

module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_kind,
    input  wire logic        [sts_pkg::INDEX_W-1:0]  i_entry_index,
    input  wire logic signed [sts_pkg::VALUE_W-1:0]  i_value,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic        [sts_pkg::LEN_W-1:0]    i_cfg_data,
    output logic                                     o_done,
    output logic                                     o_found,
    output logic             [sts_pkg::POS_W-1:0]    o_position
);

    import sts_pkg::*;

    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW1 = NW + 1;

    t_state r_state, n_state;

    logic [LEN_W-1:0]           r_len;
    logic [NW-1:0]              r_lo, n_lo;
    logic [NW-1:0]              r_hi, n_hi;
    logic [NW-1:0]              r_mid, n_mid;
    logic signed [VALUE_W-1:0]  r_key, n_key;
    logic                       r_done, n_done;
    logic                       r_found, n_found;
    logic [POS_W-1:0]           r_pos, n_pos;

    logic                       accept;
    logic [NW-1:0]              live_n;
    logic [31:0]                idx_ext;
    logic [31:0]                mid_ext;
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic signed [VALUE_W-1:0]  ram_rdata;

    logic                       hit, go_left, left_empty, right_empty;
    logic [NW1-1:0]             sum_start, sum_left, sum_right, mid_plus1;
    logic [NW-1:0]              mid_start, mid_left, mid_right, mid_next;

    assign accept      = start && !busy;
    assign busy        = (r_state == S_LOOK);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_position  = r_pos;

    // Live length saturates at the table depth.
    assign live_n = (32'(r_len) > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(r_len);

    assign idx_ext = 32'(i_entry_index);
    assign mid_ext = 32'(r_mid);
    assign ram_we  = accept && (i_kind == KIND_WRITE) && (idx_ext < 32'(TABLE_DEPTH));

    // Candidate midpoints for both halves are formed alongside the compare, so the
    // next probe address is only a select away from the compare result.
    assign sum_start   = NW1'(live_n) - NW1'(1);
    assign mid_start   = NW'(sum_start >> 1);
    assign sum_left    = NW1'(r_lo) + NW1'(r_mid) - NW1'(1);
    assign mid_left    = NW'(sum_left >> 1);
    assign sum_right   = NW1'(r_mid) + NW1'(r_hi);
    assign mid_right   = NW'(sum_right >> 1);
    assign mid_plus1   = NW1'(r_mid) + NW1'(1);
    assign left_empty  = (r_lo == r_mid);
    assign right_empty = (mid_plus1 >= NW1'(r_hi));

    assign hit      = (ram_rdata == r_key);
    assign go_left  = (ram_rdata > r_key);
    assign mid_next = go_left ? mid_left : mid_right;

    assign ram_raddr = (r_state == S_LOOK) ? mid_next[AW-1:0] : mid_start[AW-1:0];

    sts_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_SEARCH) && (live_n != '0)) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (hit || (go_left ? left_empty : right_empty)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        n_done  = 1'b0;
        n_found = 1'b0;
        n_pos   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_kind == KIND_SEARCH)) begin
                    n_key = i_value;
                    n_lo  = '0;
                    n_hi  = live_n;
                    n_mid = mid_start;
                    if (live_n == '0) begin
                        n_done = 1'b1;
                    end
                end
            end
            S_LOOK: begin
                if (hit) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_pos   = mid_ext[POS_W-1:0];
                end else if (go_left) begin
                    n_hi   = r_mid;
                    n_mid  = mid_left;
                    n_done = left_empty;
                end else begin
                    n_lo   = NW'(mid_plus1);
                    n_mid  = mid_right;
                    n_done = right_empty;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_key   <= n_key;
        r_found <= n_found;
        r_pos   <= n_pos;
    end

endmodule

`default_nettype wire
